@@ design/lru_page_replacement_defines.svh @@
// assertion macros shared by the lru page replacement rtl
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LRUPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lrupr_pkg.sv @@
// shared constants and control structs for the lru page replacement block
// no dependencies
package lrupr_pkg;

    // default sizes
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // fixed field widths
    localparam int CFG_W        = 5;
    localparam int PAGE_FIELD_W = 16;
    localparam int FRAME_W      = 4;
    localparam int COUNT_W      = 16;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 40;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // search flags carried cell to cell during a sweep
    typedef struct packed {
        logic hit;
        logic empty_found;
        logic max_set;
    } t_scan;

    // update command broadcast to all cells at the end of a request
    typedef struct packed {
        logic en;
        logic clear;
        logic fill;
        logic write_page;
    } t_upd;

endpackage

@@ design/lrupr_cell.sv @@
// one frame cell: holds page, valid and recency rank, forwards the search
// depends on lrupr_pkg and lru_page_replacement_defines.svh
`include "lru_page_replacement_defines.svh"

module lrupr_cell #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX       = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // search from the left neighbor
    input  logic                          i_tok,
    input  lrupr_pkg::t_scan              i_scan,
    input  logic [$clog2(FRAMES)-1:0]     i_hit_idx,
    input  logic [$clog2(FRAMES)-1:0]     i_hit_rank,
    input  logic [$clog2(FRAMES)-1:0]     i_empty_idx,
    input  logic [$clog2(FRAMES)-1:0]     i_max_idx,
    input  logic [$clog2(FRAMES)-1:0]     i_max_rank,
    input  logic [PAGE_BITS-1:0]          i_max_page,
    // search to the right neighbor
    output logic                          o_tok,
    output lrupr_pkg::t_scan              o_scan,
    output logic [$clog2(FRAMES)-1:0]     o_hit_idx,
    output logic [$clog2(FRAMES)-1:0]     o_hit_rank,
    output logic [$clog2(FRAMES)-1:0]     o_empty_idx,
    output logic [$clog2(FRAMES)-1:0]     o_max_idx,
    output logic [$clog2(FRAMES)-1:0]     o_max_rank,
    output logic [PAGE_BITS-1:0]          o_max_page,
    // broadcast request data and update
    input  logic [PAGE_BITS-1:0]          i_req_page,
    input  logic [$clog2(FRAMES+1)-1:0]   i_used,
    input  lrupr_pkg::t_upd               i_upd,
    input  logic [$clog2(FRAMES)-1:0]     i_upd_idx,
    input  logic [$clog2(FRAMES)-1:0]     i_upd_rank
);
    import lrupr_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int UW = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [IW-1:0]        r_rank;

    logic                 r_tok;
    t_scan                r_scan, n_scan;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [IW-1:0]        r_hit_rank, n_hit_rank;
    logic [IW-1:0]        r_empty_idx, n_empty_idx;
    logic [IW-1:0]        r_max_idx, n_max_idx;
    logic [IW-1:0]        r_max_rank, n_max_rank;
    logic [PAGE_BITS-1:0] r_max_page, n_max_page;

    logic in_use;
    logic sel;

    assign in_use = (UW'(IDX) < i_used);
    assign sel    = (i_upd_idx == IW'(IDX));

    // fold this frame into the running search
    always_comb begin
        n_scan      = i_scan;
        n_hit_idx   = i_hit_idx;
        n_hit_rank  = i_hit_rank;
        n_empty_idx = i_empty_idx;
        n_max_idx   = i_max_idx;
        n_max_rank  = i_max_rank;
        n_max_page  = i_max_page;
        if (in_use && r_valid && !i_scan.hit && (r_page == i_req_page)) begin
            n_scan.hit = 1'b1;
            n_hit_idx  = IW'(IDX);
            n_hit_rank = r_rank;
        end
        if (in_use && !r_valid && !i_scan.empty_found) begin
            n_scan.empty_found = 1'b1;
            n_empty_idx        = IW'(IDX);
        end
        if (in_use && (!i_scan.max_set || (r_rank > i_max_rank))) begin
            n_scan.max_set = 1'b1;
            n_max_idx      = IW'(IDX);
            n_max_rank     = r_rank;
            n_max_page     = r_page;
        end
    end

    // search token moves one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_scan <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_tok) begin
                r_scan <= n_scan;
            end
        end
    end

    // search payload
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_hit_idx   <= n_hit_idx;
            r_hit_rank  <= n_hit_rank;
            r_empty_idx <= n_empty_idx;
            r_max_idx   <= n_max_idx;
            r_max_rank  <= n_max_rank;
            r_max_page  <= n_max_page;
        end
    end

    // valid bit and recency rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_upd.clear) begin
                r_valid <= 1'b0;
                r_rank  <= '0;
            end else if (i_upd.fill) begin
                if (sel) begin
                    r_valid <= 1'b1;
                    r_rank  <= '0;
                end else if (r_valid) begin
                    r_rank <= r_rank + 1'b1;
                end
            end else begin
                if (sel) begin
                    r_rank <= '0;
                end else if (r_valid && (r_rank < i_upd_rank)) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

    // stored page
    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.write_page && sel) begin
            r_page <= i_req_page;
        end
    end

    assign o_tok       = r_tok;
    assign o_scan      = r_scan;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_rank  = r_hit_rank;
    assign o_empty_idx = r_empty_idx;
    assign o_max_idx   = r_max_idx;
    assign o_max_rank  = r_max_rank;
    assign o_max_page  = r_max_page;

    // a fill only lands on an empty frame, a touch only on a resident one
    `LRUPR_ASSERT_NOW(a_fill_empty, i_upd.en && !i_upd.clear && i_upd.fill && sel, !r_valid, "fill hit a resident frame")
    `LRUPR_ASSERT_NOW(a_touch_valid, i_upd.en && !i_upd.clear && !i_upd.fill && sel, r_valid, "touch on an empty frame")
    `LRUPR_ASSERT_NEXT(a_clear_empties, i_upd.en && i_upd.clear, !r_valid && (r_rank == '0), "frame not cleared")

endmodule

@@ design/lru_page_replacement.sv @@
// lru page replacement, top level: handshakes, sweep control, result register
// depends on lrupr_pkg, lrupr_cell and lru_page_replacement_defines.svh
//
//  channel   dir  signals                             content
//  s         in   i_s_tvalid o_s_tready i_s_tdata     page reference, tlast ends string
//                 i_s_tlast
//  m         out  o_m_tvalid i_m_tready o_m_tdata     hit, frame, eviction, fault total
//  cfg       in   i_cfg_wr_en i_cfg_wr_data           frames_in_use, reset 16
//
// from acceptance to acceptance a request goes through these steps: launch the
// search token, walk it along the row of cells, update the cells and load the
// result, return to idle; the result shows in the register that the update loads.
// a waiting result does not block acceptance; the update waits while the result
// register is full and i_m_tready is low.
// synchronous reset empties all frames, zeroes the fault count, sets frames_in_use to 16.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // page[15:0]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lrupr_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                            i_s_tlast,
    // hit[0], frame[4:1], evicted_valid[5], evicted_page[21:6],
    // fault_total[37:22], zero[39:38]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lrupr_pkg::M_TDATA_W-1:0] o_m_tdata,
    // frames_in_use
    input  logic                            i_cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0]     i_cfg_wr_data
);
    import lrupr_pkg::*;

    localparam int IW = $clog2(FRAMES);
    localparam int UW = $clog2(FRAMES + 1);
    localparam int CW = (UW > CFG_W) ? UW : CFG_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SWEEP  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CFG_W-1:0]       r_cfg;
    logic [PAGE_BITS-1:0]   r_page;
    logic                   r_last;
    logic                   r_start;
    logic [COUNT_W-1:0]     r_fault, n_fault;

    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [FRAME_W-1:0]     r_out_frame;
    logic                   r_out_ev;
    logic [PAGE_FIELD_W-1:0] r_out_evp;
    logic [COUNT_W-1:0]     r_out_fault;

    // cell chain links, entry 0 is the head of the row
    logic [FRAMES:0]        tok;
    t_scan                  scan      [FRAMES+1];
    logic [IW-1:0]          hit_idx   [FRAMES+1];
    logic [IW-1:0]          hit_rank  [FRAMES+1];
    logic [IW-1:0]          empty_idx [FRAMES+1];
    logic [IW-1:0]          max_idx   [FRAMES+1];
    logic [IW-1:0]          max_rank  [FRAMES+1];
    logic [PAGE_BITS-1:0]   max_page  [FRAMES+1];

    logic                   s_fire;
    logic                   upd_fire;
    logic [CW-1:0]          cfg_ext;
    logic [CW-1:0]          used_c;
    logic [UW-1:0]          used;
    logic [PAGE_BITS+15:0]  page_ext;
    logic [PAGE_BITS+15:0]  evp_ext;
    logic [IW+3:0]          frame_ext;
    t_upd                   upd;
    logic [IW-1:0]          upd_idx;
    logic [IW-1:0]          upd_rank;
    logic                   res_hit;
    logic                   res_ev;

    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign upd_fire   = (r_state == S_UPDATE) && (!r_out_valid || i_m_tready);

    // frames in use, clamped to 1..FRAMES
    assign cfg_ext = CW'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            used_c = CW'(1);
        end else if (cfg_ext > CW'(FRAMES)) begin
            used_c = CW'(FRAMES);
        end else begin
            used_c = cfg_ext;
        end
    end
    assign used = used_c[UW-1:0];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // request capture
    assign page_ext = {PAGE_BITS'(0), i_s_tdata};
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_page <= page_ext[PAGE_BITS-1:0];
            r_last <= i_s_tlast;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (tok[FRAMES]) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (upd_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= s_fire;
        end
    end

    // head of the search
    assign tok[0]       = r_start;
    assign scan[0]      = '0;
    assign hit_idx[0]   = '0;
    assign hit_rank[0]  = '0;
    assign empty_idx[0] = '0;
    assign max_idx[0]   = '0;
    assign max_rank[0]  = '0;
    assign max_page[0]  = '0;

    // row of frame cells
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (tok[g]),
            .i_scan      (scan[g]),
            .i_hit_idx   (hit_idx[g]),
            .i_hit_rank  (hit_rank[g]),
            .i_empty_idx (empty_idx[g]),
            .i_max_idx   (max_idx[g]),
            .i_max_rank  (max_rank[g]),
            .i_max_page  (max_page[g]),
            .o_tok       (tok[g+1]),
            .o_scan      (scan[g+1]),
            .o_hit_idx   (hit_idx[g+1]),
            .o_hit_rank  (hit_rank[g+1]),
            .o_empty_idx (empty_idx[g+1]),
            .o_max_idx   (max_idx[g+1]),
            .o_max_rank  (max_rank[g+1]),
            .o_max_page  (max_page[g+1]),
            .i_req_page  (r_page),
            .i_used      (used),
            .i_upd       (upd),
            .i_upd_idx   (upd_idx),
            .i_upd_rank  (upd_rank)
        );
    end

    // decide hit, fill or evict from the end of the row
    always_comb begin
        res_hit        = scan[FRAMES].hit;
        res_ev         = 1'b0;
        upd.en         = upd_fire;
        upd.clear      = r_last;
        upd.fill       = 1'b0;
        upd.write_page = 1'b0;
        upd_idx        = hit_idx[FRAMES];
        upd_rank       = hit_rank[FRAMES];
        if (!scan[FRAMES].hit) begin
            upd.write_page = 1'b1;
            if (scan[FRAMES].empty_found) begin
                upd.fill = 1'b1;
                upd_idx  = empty_idx[FRAMES];
            end else begin
                res_ev   = 1'b1;
                upd_idx  = max_idx[FRAMES];
                upd_rank = max_rank[FRAMES];
            end
        end
    end

    // saturating fault count, cleared by the last request of a string
    always_comb begin
        n_fault = r_fault;
        if (!res_hit && (r_fault != COUNT_MAX)) begin
            n_fault = r_fault + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (upd_fire) begin
            r_fault <= r_last ? '0 : n_fault;
        end
    end

    // result register
    assign evp_ext   = {16'b0, max_page[FRAMES]};
    assign frame_ext = {4'b0, upd_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_hit   <= res_hit;
            r_out_frame <= frame_ext[FRAME_W-1:0];
            r_out_ev    <= res_ev;
            r_out_evp   <= res_ev ? evp_ext[PAGE_FIELD_W-1:0] : '0;
            r_out_fault <= n_fault;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_fault, r_out_evp, r_out_ev, r_out_frame, r_out_hit};

    // one request in the row at a time, none while idle, results always land
    `LRUPR_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok), "more than one search in flight")
    `LRUPR_ASSERT_NOW(a_idle_empty, r_state == S_IDLE, tok == '0, "search token while idle")
    `LRUPR_ASSERT_NEXT(a_result_out, upd_fire, o_m_tvalid, "result not presented after update")
    `LRUPR_ASSERT_NEXT(a_fault_mono, upd_fire && !r_last, r_fault >= $past(r_fault), "fault count went down")

endmodule

@@ tb/lru_page_replacement_checker.sv @@
// checker for the lru page replacement block: watches the request, result and
// register channels, predicts each result and compares it field by field
// depends on lrupr_pkg
module lru_page_replacement_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // page[15:0]
    input  logic [lrupr_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                            i_s_tlast,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // hit[0], frame[4:1], evicted_valid[5], evicted_page[21:6],
    // fault_total[37:22], zero[39:38]
    input  logic [lrupr_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [lrupr_pkg::CFG_W-1:0]     i_cfg_wr_data,
    output int                              o_pending,
    output int                              o_fail_count
);
    import lrupr_pkg::*;

    localparam int NFRAMES    = FRAMES_DEF;
    localparam int MAX_REPORT = 50;

    typedef struct packed {
        logic                    hit;
        logic [FRAME_W-1:0]      frame;
        logic                    evicted_valid;
        logic [PAGE_FIELD_W-1:0] evicted_page;
        logic [COUNT_W-1:0]      fault_total;
    } t_outcome;

    // predicted copy of the block state and its register
    logic [CFG_W-1:0]        frames_cfg;
    logic [PAGE_FIELD_W-1:0] resident_page [NFRAMES];
    logic                    resident_valid [NFRAMES];
    logic [FRAME_W-1:0]      age_rank [NFRAMES];
    logic [COUNT_W-1:0]      faults;

    t_outcome expected_outcomes [$];
    int       fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic clear_frames();
        for (int i = 0; i < NFRAMES; i++) begin
            resident_page[i]  = '0;
            resident_valid[i] = 1'b0;
            age_rank[i]       = '0;
        end
        faults = '0;
    endtask

    // frame k becomes most recent, younger valid frames age by one
    task automatic make_recent(input int k);
        logic [FRAME_W-1:0] r;
        r = age_rank[k];
        for (int i = 0; i < NFRAMES; i++) begin
            if (resident_valid[i] && i != k && age_rank[i] < r) begin
                age_rank[i] = age_rank[i] + 1'b1;
            end
        end
        age_rank[k] = '0;
    endtask

    // a new frame turns valid, every valid frame ages by one
    task automatic admit_frame(input int k);
        for (int i = 0; i < NFRAMES; i++) begin
            if (resident_valid[i]) begin
                age_rank[i] = age_rank[i] + 1'b1;
            end
        end
        resident_valid[k] = 1'b1;
        age_rank[k]       = '0;
    endtask

    // lookup, fill or evict for one page request
    task automatic apply_reference(input logic [PAGE_FIELD_W-1:0] page, input logic last,
                                   output t_outcome o);
        int   span;
        int   k;
        logic found_hit;
        logic found_empty;
        span        = int'(frames_cfg);
        k           = 0;
        found_hit   = 1'b0;
        found_empty = 1'b0;
        o           = '0;
        if (span < 1) span = 1;
        if (span > NFRAMES) span = NFRAMES;

        // lowest-index matching frame wins
        for (int i = 0; i < span; i++) begin
            if (!found_hit && resident_valid[i] && resident_page[i] == page) begin
                found_hit = 1'b1;
                k         = i;
            end
        end

        if (found_hit) begin
            make_recent(k);
        end else begin
            for (int i = 0; i < span; i++) begin
                if (!found_empty && !resident_valid[i]) begin
                    found_empty = 1'b1;
                    k           = i;
                end
            end
            if (found_empty) begin
                resident_page[k] = page;
                admit_frame(k);
            end else begin
                // oldest frame in range, first one on a tie
                k = 0;
                for (int i = 1; i < span; i++) begin
                    if (age_rank[i] > age_rank[k]) k = i;
                end
                o.evicted_valid  = 1'b1;
                o.evicted_page   = resident_page[k];
                resident_page[k] = page;
                make_recent(k);
            end
            if (faults != COUNT_MAX) faults = faults + 1'b1;
        end

        o.hit         = found_hit;
        o.frame       = k[FRAME_W-1:0];
        o.fault_total = faults;
        if (last) clear_frames();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORT) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    // monitor: result first so that a stray result is never matched to a new request
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome fresh;
        if (!i_rst_n) begin
            frames_cfg = CFG_RESET;
            clear_frames();
            expected_outcomes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT) begin
                        $display("%0t: result with none expected, actual %0h", $time,
                                 i_m_tdata);
                    end
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("hit", 32'(want.hit), 32'(i_m_tdata[0]));
                    check_field("frame", 32'(want.frame), 32'(i_m_tdata[4:1]));
                    check_field("evicted_valid", 32'(want.evicted_valid), 32'(i_m_tdata[5]));
                    check_field("evicted_page", 32'(want.evicted_page), 32'(i_m_tdata[21:6]));
                    check_field("fault_total", 32'(want.fault_total), 32'(i_m_tdata[37:22]));
                    check_field("pad", 32'd0, 32'(i_m_tdata[39:38]));
                end
            end
            if (i_cfg_wr_en) begin
                frames_cfg = i_cfg_wr_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_reference(i_s_tdata[PAGE_FIELD_W-1:0], i_s_tlast, fresh);
                expected_outcomes.push_back(fresh);
            end
        end
        o_pending = expected_outcomes.size();
    end

endmodule

@@ tb/lru_page_replacement_tb.sv @@
// testbench top for lru_page_replacement: clock, reset, request and register
// stimulus, receiver stalls and the final verdict
// depends on lrupr_pkg, lru_page_replacement and lru_page_replacement_checker
module lru_page_replacement_tb;
    import lrupr_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = FRAMES_DEF + 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENTS      = 12;
    localparam int SEG_ITEMS     = 125;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_TDATA_W-1:0]    i_s_tdata;
    logic                    i_s_tlast;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_TDATA_W-1:0]    o_m_tdata;
    logic                    i_cfg_wr_en;
    logic [CFG_W-1:0]        i_cfg_wr_data;

    int pending;
    int fail_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    bit hold_pending  = 1'b0;

    lru_page_replacement DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    lru_page_replacement_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lru_page_replacement: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_pending = 1'b0;
            end else begin
                i_m_tready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // wait until every expected result is in, then let the block settle
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // one page request; returns at the negedge after acceptance with valid still high
    task automatic send_ref(input logic [S_TDATA_W-1:0] page, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = page;
        i_s_tlast  = last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic quiet_sender();
        i_s_tvalid = 1'b0;
        i_s_tlast  = 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                rx_stall_pct  = 0;
            end
            1: begin
                send_idle_pct = 62;
                rx_stall_pct  = 0;
            end
            2: begin
                send_idle_pct = 0;
                rx_stall_pct  = 62;
            end
            default: begin
                send_idle_pct = 38;
                rx_stall_pct  = 38;
            end
        endcase
    endtask

    // stimulus
    initial begin
        logic [CFG_W-1:0]     extremes [6];
        logic [CFG_W-1:0]     cfg_value;
        logic [S_TDATA_W-1:0] pool_base;
        logic [S_TDATA_W-1:0] page;
        int                   pool_size;

        extremes      = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2};
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset setting, field extremes, hit and eviction
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'hFFFF, 1'b1);
        quiet_sender();
        write_frames(5'd3);
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'h8000, 1'b1);
        quiet_sender();

        // zero frames behaves as one
        write_frames(5'd0);
        send_ref(16'h0007, 1'b0);
        send_ref(16'h0007, 1'b0);
        send_ref(16'h0009, 1'b1);
        quiet_sender();

        // register above the frame count saturates
        write_frames(5'd31);
        send_ref(16'h1111, 1'b0);
        send_ref(16'h2222, 1'b1);
        quiet_sender();

        // range shrunk mid-string, then grown to expose a duplicated page
        write_frames(5'd4);
        send_ref(16'h0001, 1'b0);
        send_ref(16'h0002, 1'b0);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h0004, 1'b0);
        quiet_sender();
        write_frames(5'd2);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h0005, 1'b0);
        quiet_sender();
        write_frames(5'd4);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h0004, 1'b1);
        quiet_sender();

        // random strings over small page pools, strings run across register writes
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            cfg_value = (seg < 6) ? extremes[seg] : CFG_W'($urandom_range(0, 31));
            write_frames(cfg_value);
            set_idling(seg % 4);
            if (seg == 1 || seg == 6) hold_pending = 1'b1;
            pool_size = $urandom_range(2, 24);
            pool_base = S_TDATA_W'($urandom);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                // sender pause until the block has drained
                if (seg == 3 && n == SEG_ITEMS / 2) begin
                    quiet_sender();
                    while (pending != 0) @(negedge i_clk);
                end
                if ($urandom_range(99) < 85) begin
                    page = pool_base + S_TDATA_W'($urandom_range(0, pool_size - 1));
                end else begin
                    page = S_TDATA_W'($urandom);
                end
                send_ref(page, ($urandom_range(39) == 0));
                if ($urandom_range(49) == 0) begin
                    pool_size = $urandom_range(2, 24);
                    pool_base = S_TDATA_W'($urandom);
                end
            end
            quiet_sender();
        end

        // drain and verdict
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("lru_page_replacement: match");
        end else begin
            $display("lru_page_replacement: mismatch");
        end
        $finish;
    end

endmodule
